/* src/wphf_pkg.sv */
// Shared widths, constants, codes, control structs and the arctangent table.
package wphf_pkg;

  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned NUM_SLOTS  = 16;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned YAW_W      = 15;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned LIM_W      = 15;
  localparam int unsigned SLOW_W     = 14;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned DELTA_W      = POS_W + 1;
  localparam int unsigned SQ_W         = 2 * POS_W;
  localparam int unsigned CORDIC_STEPS = 14;
  localparam int unsigned STEP_W       = $clog2(CORDIC_STEPS);
  localparam int unsigned PRESCALE_SH  = 8;
  localparam int unsigned CORDIC_W     = DELTA_W + PRESCALE_SH + 3;
  localparam int unsigned ANG_W        = 16;
  localparam int unsigned ERR_W        = 17;
  localparam int unsigned PROD_W       = GAIN_W + 1 + ERR_W;
  localparam int unsigned FRAC_SH      = 12;

  localparam int PI_Q12      = 12868;
  localparam int HALF_PI_Q12 = 6434;
  localparam int ROUND_HALF  = 2048;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_POSE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRUISE = 3'd0,
    CFG_RADIUS = 3'd1,
    CFG_GAIN   = 3'd2,
    CFG_LIMIT  = 3'd3,
    CFG_SLOW   = 3'd4,
    CFG_LOOP   = 3'd5,
    CFG_LENGTH = 3'd6
  } cfg_idx_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load_write;
    logic pose_latch;
    logic delta;
    logic square;
    logic advance;
    logic cinit;
    logic citer;
    logic err;
    logic mul;
    logic out_load;
    logic out_finish;
  } wphf_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic arrive;
    logic finish;
    logic cordic_last;
  } wphf_sts_t;

  // Rounded Q3.12 arctangent of 2^-i
  function automatic logic signed [ANG_W-1:0] atan_q12(input logic [4:0] idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      5'd0:    a = 16'sd3217;
      5'd1:    a = 16'sd1899;
      5'd2:    a = 16'sd1003;
      5'd3:    a = 16'sd509;
      5'd4:    a = 16'sd256;
      5'd5:    a = 16'sd128;
      5'd6:    a = 16'sd64;
      5'd7:    a = 16'sd32;
      5'd8:    a = 16'sd16;
      5'd9:    a = 16'sd8;
      5'd10:   a = 16'sd4;
      5'd11:   a = 16'sd2;
      5'd12:   a = 16'sd1;
      default: a = 16'sd0;
    endcase
    return a;
  endfunction

endpackage

/* src/wphf_in_if.sv */
// Input channel: load and pose requests with valid/ready handshake.
interface wphf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  command;
  logic [wphf_pkg::SLOT_W-1:0]           slot;
  logic signed [wphf_pkg::POS_W-1:0]     way_x;
  logic signed [wphf_pkg::POS_W-1:0]     way_y;
  logic signed [wphf_pkg::POS_W-1:0]     pose_x;
  logic signed [wphf_pkg::POS_W-1:0]     pose_y;
  logic signed [wphf_pkg::YAW_W-1:0]     pose_yaw;

  modport source (output valid, command, slot, way_x, way_y, pose_x, pose_y, pose_yaw,
                  input ready);
  modport sink (input valid, command, slot, way_x, way_y, pose_x, pose_y, pose_yaw,
                output ready);
endinterface

/* src/wphf_out_if.sv */
// Output channel: steering command requests with valid/ready handshake.
interface wphf_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [wphf_pkg::SPEED_W-1:0]          forward_speed;
  logic signed [wphf_pkg::RATE_W-1:0]    turn_rate;
  logic [wphf_pkg::SLOT_W-1:0]           target_slot;
  logic                                  finished;

  modport source (output valid, forward_speed, turn_rate, target_slot, finished,
                  input ready);
  modport sink (input valid, forward_speed, turn_rate, target_slot, finished,
                output ready);
endinterface

/* src/wphf_ctrl.sv */
// Sequencer: steps one pose request through fetch, arrival check, CORDIC and output.
module wphf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_command_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  wphf_pkg::wphf_sts_t sts_i,
  output wphf_pkg::wphf_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DELTA,
    ST_SQUARE,
    ST_CHECK,
    ST_CINIT,
    ST_CITER,
    ST_ERR,
    ST_MUL,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   second_q;
  logic   halted_q;
  logic   finish_q;
  logic   out_valid_q;
  logic   in_fire;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load_write = in_fire && (in_command_i == wphf_pkg::CMD_LOAD);
    cmd_o.pose_latch = in_fire && (in_command_i == wphf_pkg::CMD_POSE) && !halted_q;
    cmd_o.delta      = (state_q == ST_DELTA);
    cmd_o.square     = (state_q == ST_SQUARE);
    cmd_o.advance    = (state_q == ST_CHECK) && sts_i.arrive && !sts_i.finish;
    cmd_o.cinit      = (state_q == ST_CINIT);
    cmd_o.citer      = (state_q == ST_CITER);
    cmd_o.err        = (state_q == ST_ERR);
    cmd_o.mul        = (state_q == ST_MUL);
    cmd_o.out_load   = (state_q == ST_OUT) && out_free;
    cmd_o.out_finish = finish_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      second_q    <= 1'b0;
      halted_q    <= 1'b0;
      finish_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.pose_latch) begin
            second_q <= 1'b0;
            finish_q <= 1'b0;
            state_q  <= ST_FETCH;
          end
        end
        ST_FETCH: state_q <= ST_DELTA;
        ST_DELTA: state_q <= second_q ? ST_CINIT : ST_SQUARE;
        ST_SQUARE: state_q <= ST_CHECK;
        ST_CHECK: begin
          if (sts_i.finish) begin
            // last waypoint reached with looping off: stop for good
            halted_q <= 1'b1;
            finish_q <= 1'b1;
            state_q  <= ST_OUT;
          end else if (sts_i.arrive) begin
            second_q <= 1'b1;
            state_q  <= ST_FETCH;
          end else begin
            state_q <= ST_CINIT;
          end
        end
        ST_CINIT: state_q <= ST_CITER;
        ST_CITER: begin
          if (sts_i.cordic_last) begin
            state_q <= ST_ERR;
          end
        end
        ST_ERR: state_q <= ST_MUL;
        ST_MUL: state_q <= ST_OUT;
        ST_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/wphf_dp.sv */
// Datapath: config registers, route table, distance check, CORDIC atan2, rate law.
module wphf_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  wphf_pkg::wphf_cmd_t                    cmd_i,
  output wphf_pkg::wphf_sts_t                    sts_o,
  input  logic                                   cfg_we_i,
  input  logic [wphf_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [wphf_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic [wphf_pkg::SLOT_W-1:0]            slot_i,
  input  logic signed [wphf_pkg::POS_W-1:0]      way_x_i,
  input  logic signed [wphf_pkg::POS_W-1:0]      way_y_i,
  input  logic signed [wphf_pkg::POS_W-1:0]      pose_x_i,
  input  logic signed [wphf_pkg::POS_W-1:0]      pose_y_i,
  input  logic signed [wphf_pkg::YAW_W-1:0]      pose_yaw_i,
  output logic [wphf_pkg::SPEED_W-1:0]           forward_speed_o,
  output logic signed [wphf_pkg::RATE_W-1:0]     turn_rate_o,
  output logic [wphf_pkg::SLOT_W-1:0]            target_slot_o,
  output logic                                   finished_o
);

  localparam int unsigned CW    = wphf_pkg::CORDIC_W;
  localparam int unsigned EW    = wphf_pkg::ERR_W;
  localparam int unsigned EXT_W = wphf_pkg::ERR_W + 1;
  localparam int unsigned PW    = wphf_pkg::PROD_W;
  localparam int unsigned RFW   = wphf_pkg::PROD_W + 1 - wphf_pkg::FRAC_SH;
  localparam int unsigned DW    = wphf_pkg::DELTA_W;
  localparam int unsigned SW    = wphf_pkg::STEP_W;
  localparam int unsigned AW    = wphf_pkg::ANG_W;

  localparam logic signed [EXT_W-1:0] PI_E     = EXT_W'(wphf_pkg::PI_Q12);
  localparam logic signed [EXT_W-1:0] TWO_PI_E = EXT_W'(2 * wphf_pkg::PI_Q12);
  localparam logic signed [AW-1:0]    HALF_PI  = AW'(wphf_pkg::HALF_PI_Q12);

  // configuration
  logic [wphf_pkg::SPEED_W-1:0] cruise_q;
  logic [wphf_pkg::POS_W-1:0]   radius_q;
  logic [wphf_pkg::GAIN_W-1:0]  gain_q;
  logic [wphf_pkg::LIM_W-1:0]   limit_q;
  logic [wphf_pkg::SLOW_W-1:0]  slow_q;
  logic                         loop_q;
  logic [wphf_pkg::LEN_W-1:0]   length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cruise_q <= 16'd128;
      radius_q <= 16'd77;
      gain_q   <= 16'd6144;
      limit_q  <= 15'd6144;
      slow_q   <= 14'd3277;
      loop_q   <= 1'b1;
      length_q <= 5'd4;
    end else if (cfg_we_i) begin
      unique case (wphf_pkg::cfg_idx_e'(cfg_idx_i))
        wphf_pkg::CFG_CRUISE: cruise_q <= cfg_wdata_i;
        wphf_pkg::CFG_RADIUS: radius_q <= cfg_wdata_i;
        wphf_pkg::CFG_GAIN:   gain_q   <= cfg_wdata_i;
        wphf_pkg::CFG_LIMIT:  limit_q  <= cfg_wdata_i[wphf_pkg::LIM_W-1:0];
        wphf_pkg::CFG_SLOW:   slow_q   <= cfg_wdata_i[wphf_pkg::SLOW_W-1:0];
        wphf_pkg::CFG_LOOP:   loop_q   <= cfg_wdata_i[0];
        wphf_pkg::CFG_LENGTH: length_q <= cfg_wdata_i[wphf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate route length to [2, table depth]
  logic [wphf_pkg::LEN_W-1:0] len;
  always_comb begin
    if (length_q < 5'd2) begin
      len = 5'd2;
    end else if (length_q > 5'(wphf_pkg::NUM_SLOTS)) begin
      len = 5'(wphf_pkg::NUM_SLOTS);
    end else begin
      len = length_q;
    end
  end

  // route table and target pointer
  logic [2*wphf_pkg::POS_W-1:0] route_mem [wphf_pkg::NUM_SLOTS];
  logic [2*wphf_pkg::POS_W-1:0] rd_q;
  logic [wphf_pkg::SLOT_W-1:0]  target_q;
  logic                         last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_write) begin
      route_mem[slot_i] <= {way_y_i, way_x_i};
    end
    rd_q <= route_mem[target_q];
  end

  assign last = ({1'b0, target_q} + 5'd1) >= len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cmd_i.advance) begin
      target_q <= last ? '0 : target_q + 1'b1;
    end
  end

  // pose capture and deltas
  logic signed [wphf_pkg::POS_W-1:0] px_q, py_q;
  logic signed [wphf_pkg::YAW_W-1:0] yaw_q;
  logic signed [DW-1:0]              dx_q, dy_q, dx_d, dy_d;
  logic signed [wphf_pkg::POS_W-1:0] wx, wy;
  logic                              zero_q;

  assign wx   = $signed(rd_q[wphf_pkg::POS_W-1:0]);
  assign wy   = $signed(rd_q[2*wphf_pkg::POS_W-1:wphf_pkg::POS_W]);
  assign dx_d = DW'(wx) - DW'(px_q);
  assign dy_d = DW'(wy) - DW'(py_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pose_latch) begin
      px_q  <= pose_x_i;
      py_q  <= pose_y_i;
      yaw_q <= pose_yaw_i;
    end
    if (cmd_i.delta) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      zero_q <= (dx_d == '0) && (dy_d == '0);
    end
  end

  // squared distance against squared radius
  logic signed [2*DW-1:0]       dxx, dyy;
  logic [wphf_pkg::SQ_W-1:0]    dx2_q, dy2_q, r2_q;

  assign dxx = dx_q * dx_q;
  assign dyy = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      dx2_q <= dxx[wphf_pkg::SQ_W-1:0];
      dy2_q <= dyy[wphf_pkg::SQ_W-1:0];
      r2_q  <= radius_q * radius_q;
    end
  end

  assign sts_o.arrive = ({1'b0, dx2_q} + {1'b0, dy2_q}) < {1'b0, r2_q};
  assign sts_o.finish = sts_o.arrive && last && !loop_q;

  // vectoring CORDIC, one micro-rotation per cycle
  logic signed [CW-1:0] cx_q, cy_q, xe, ye, xs, ys;
  logic signed [AW-1:0] cz_q, ang;
  logic [SW-1:0]        iter_q;

  assign xe  = CW'(dx_q) <<< wphf_pkg::PRESCALE_SH;
  assign ye  = CW'(dy_q) <<< wphf_pkg::PRESCALE_SH;
  assign xs  = cx_q >>> iter_q;
  assign ys  = cy_q >>> iter_q;
  assign ang = wphf_pkg::atan_q12(5'(iter_q));
  assign sts_o.cordic_last = (iter_q == SW'(wphf_pkg::CORDIC_STEPS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.cinit) begin
      iter_q <= '0;
      // rotate into the right half plane first
      if (!xe[CW-1]) begin
        cx_q <= xe;
        cy_q <= ye;
        cz_q <= '0;
      end else if (!ye[CW-1]) begin
        cx_q <= ye;
        cy_q <= -xe;
        cz_q <= HALF_PI;
      end else begin
        cx_q <= -ye;
        cy_q <= xe;
        cz_q <= -HALF_PI;
      end
    end else if (cmd_i.citer) begin
      iter_q <= iter_q + 1'b1;
      if (!cy_q[CW-1]) begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + ang;
      end else begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - ang;
      end
    end
  end

  // heading error wrapped into (-pi, pi]
  logic signed [EXT_W-1:0] e_raw, e_wrap;
  logic signed [EW-1:0]    err_q;

  always_comb begin
    e_raw = (zero_q ? '0 : EXT_W'(cz_q)) - EXT_W'(yaw_q);
    if (e_raw > PI_E) begin
      e_wrap = e_raw - TWO_PI_E;
    end else if (e_raw <= -PI_E) begin
      e_wrap = e_raw + TWO_PI_E;
    end else begin
      e_wrap = e_raw;
    end
  end

  logic signed [PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.err) begin
      err_q <= e_wrap[EW-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= $signed({1'b0, gain_q}) * err_q;
    end
  end

  // round, shift and clamp the rate; gate speed on error magnitude
  logic signed [PW:0]      rsum;
  logic signed [RFW-1:0]   rate_full, lim_s, rate_c;
  logic [EW-1:0]           abs_err;
  logic [wphf_pkg::SPEED_W-1:0] speed;

  always_comb begin
    rsum      = (PW+1)'(prod_q) + (PW+1)'(wphf_pkg::ROUND_HALF);
    rate_full = $signed(rsum[PW:wphf_pkg::FRAC_SH]);
    lim_s     = $signed(RFW'(limit_q));
    if (rate_full > lim_s) begin
      rate_c = lim_s;
    end else if (rate_full < -lim_s) begin
      rate_c = -lim_s;
    end else begin
      rate_c = rate_full;
    end
    abs_err = err_q[EW-1] ? EW'(-err_q) : EW'(err_q);
    speed   = (abs_err < EW'(slow_q)) ? cruise_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      target_slot_o <= target_q;
      if (cmd_i.out_finish) begin
        forward_speed_o <= '0;
        turn_rate_o     <= '0;
        finished_o      <= 1'b1;
      end else begin
        forward_speed_o <= speed;
        turn_rate_o     <= rate_c[wphf_pkg::RATE_W-1:0];
        finished_o      <= 1'b0;
      end
    end
  end

endmodule

/* src/waypoint_heading_follower.sv */
// Waypoint follower top level: sequencer plus datapath behind two handshake channels.
// A pose result waits on the 14-step iterative CORDIC, longer when the target advances
// (fetch and delta repeat); the final stop skips the CORDIC.
// The next request enters the cycle after the result is loaded, so one pose is in flight
// at a time; a waiting result holds only ST_OUT.
// Reset clears target and halt flag and sets config registers to defaults; the route table is not cleared.
module waypoint_heading_follower (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  wphf_in_if.sink                          req_i,
  wphf_out_if.source                       res_o,
  input  logic                             cfg_we_i,
  input  logic [wphf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wphf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  wphf_pkg::wphf_cmd_t cmd;
  wphf_pkg::wphf_sts_t sts;

  wphf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_command_i (req_i.command),
    .in_ready_o   (req_i.ready),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  wphf_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .slot_i          (req_i.slot),
    .way_x_i         (req_i.way_x),
    .way_y_i         (req_i.way_y),
    .pose_x_i        (req_i.pose_x),
    .pose_y_i        (req_i.pose_y),
    .pose_yaw_i      (req_i.pose_yaw),
    .forward_speed_o (res_o.forward_speed),
    .turn_rate_o     (res_o.turn_rate),
    .target_slot_o   (res_o.target_slot),
    .finished_o      (res_o.finished)
  );

  a_finish_is_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.finished |-> res_o.forward_speed == '0 && res_o.turn_rate == '0)
    else $error("finish result carries a nonzero command");

  a_silent_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.ready && res_o.finished |=> !res_o.valid)
    else $error("result issued after finish");

  a_rate_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.turn_rate != 16'sh8000)
    else $error("turn rate outside clamp range");

endmodule
